### rtl/core/ice_pkg.sv
package ice_pkg;

   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_LIMIT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_L4_LIMIT     = 1'b1;

   localparam logic [15:0] HEADER_LIMIT_RESET = 16'd20;
   localparam logic [15:0] L4_LIMIT_RESET     = 16'd1480;

   localparam logic [1:0] BYTES_ONE  = 2'd1;
   localparam logic [1:0] BYTES_TWO  = 2'd2;
   localparam logic [1:0] BYTES_WIDE = 2'd3;

   typedef struct packed {
      logic        first_item;
      logic        l4_mode;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [7:0]  protocol;
      logic [15:0] data_word;
      logic [1:0]  byte_count;
      logic        last_item;
   } req_type;

   typedef struct packed {
      logic [15:0] checksum;
      logic [15:0] region_bytes;
   } rsp_type;

   // input-register contents: data word already masked, pseudo-header pre-folded
   typedef struct packed {
      logic        first_item;
      logic        l4_mode;
      logic [15:0] ph_sum;
      logic [15:0] data_word;
      logic [1:0]  byte_count;
      logic        last_item;
   } stage_type;

   // one's-complement add with end-around carry; zero only when both are zero
   function automatic logic [15:0] oc_add16(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] t;
      t = {1'b0, a} + {1'b0, b};
      return t[15:0] + {15'b0, t[16]};
   endfunction

endpackage

### rtl/core/ice_accum.sv
module ice_accum (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  ice_pkg::stage_type  stage,
   input  logic [15:0]         header_limit,
   input  logic [15:0]         l4_limit,
   output logic [15:0]         sum_ff,
   output logic [15:0]         bytes_ff,
   output logic                mode_ff
);
   import ice_pkg::*;

   logic [15:0] sum_in;
   logic [15:0] bytes_in;
   logic        mode_in;

   logic [15:0] base_sum;
   logic [15:0] base_bytes;
   logic        base_mode;
   logic [15:0] limit;
   logic        take_word;
   logic [16:0] bytes_raw;

   always_comb begin
      base_sum   = stage.first_item ? stage.ph_sum : sum_ff;
      base_bytes = stage.first_item ? 16'd0 : bytes_ff;
      base_mode  = stage.first_item ? stage.l4_mode : mode_ff;
      limit      = base_mode ? l4_limit : header_limit;
      // sum a word only if it starts inside the limit; count it regardless
      take_word  = (stage.byte_count != 2'd0) && (base_bytes < limit);
      bytes_raw  = {1'b0, base_bytes} + {15'b0, stage.byte_count};

      sum_in   = sum_ff;
      bytes_in = bytes_ff;
      mode_in  = mode_ff;
      if (advance) begin
         sum_in   = take_word ? oc_add16(base_sum, stage.data_word) : base_sum;
         bytes_in = bytes_raw[16] ? 16'hffff : bytes_raw[15:0];
         mode_in  = base_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= 16'd0;
         bytes_ff <= 16'd0;
         mode_ff  <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         bytes_ff <= bytes_in;
         mode_ff  <= mode_in;
      end
   end

endmodule

### rtl/core/internet_checksum_engine.sv
// channel | direction | handshake          | payload
// req     | in        | req_valid/req_stall | req_data (req_type)
// rsp     | out       | rsp_valid/rsp_stall | rsp_data (rsp_type)
// csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One word per cycle while the result side does not stall; a result is registered after its
// last word is taken through the input register, the accumulator update, then the result register.
// The accumulator's single 16-bit end-around-carry add sets the per-word rate.
// Synchronous reset clears the running sum, byte count and mode and loads the limits
// (header 20, L4 1480). A stalled result holds the pipe; non-last words still drain.
module internet_checksum_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  ice_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output ice_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [ice_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                  csr_data
);
   import ice_pkg::*;

   logic [15:0] hdr_limit_ff, hdr_limit_in;
   logic [15:0] l4_limit_ff, l4_limit_in;

   stage_type   stage_ff, stage_in;
   logic        stage_valid_ff, stage_valid_in;
   logic        acc_valid_ff, acc_valid_in;
   logic        acc_last_ff, acc_last_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        out_free, acc_go, acc_free, stage_go, stage_free, req_accept;
   logic [18:0] ph_raw;
   logic [16:0] ph_fold;
   logic [1:0]  nb;
   logic [15:0] acc_sum, acc_bytes, final_sum;
   logic        acc_mode;

   // handshake chain from the result side back to the input
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign acc_go     = acc_valid_ff && (!acc_last_ff || out_free);
   assign acc_free   = !acc_valid_ff || acc_go;
   assign stage_go   = stage_valid_ff && acc_free;
   assign stage_free = !stage_valid_ff || stage_go;
   assign req_accept = req_valid && stage_free;
   assign req_stall  = !stage_free;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // input side: normalize byte count, mask the pad byte, pre-fold pseudo-header
   always_comb begin
      ph_raw  = {3'b0, req_data.src_addr[31:16]} + {3'b0, req_data.src_addr[15:0]}
              + {3'b0, req_data.dst_addr[31:16]} + {3'b0, req_data.dst_addr[15:0]}
              + {11'b0, req_data.protocol};
      ph_fold = {1'b0, ph_raw[15:0]} + {14'b0, ph_raw[18:16]};
      nb      = (req_data.byte_count == BYTES_WIDE) ? BYTES_TWO : req_data.byte_count;

      stage_in = stage_ff;
      if (req_accept) begin
         stage_in.first_item = req_data.first_item;
         stage_in.l4_mode    = req_data.l4_mode;
         stage_in.ph_sum     = req_data.l4_mode ? (ph_fold[15:0] + {15'b0, ph_fold[16]})
                                                : 16'd0;
         stage_in.data_word  = (nb == BYTES_ONE) ? {req_data.data_word[15:8], 8'h00}
                                                 : req_data.data_word;
         stage_in.byte_count = nb;
         stage_in.last_item  = req_data.last_item;
      end
      stage_valid_in = stage_free ? req_valid : stage_valid_ff;
   end

   ice_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .advance      (stage_go),
      .stage        (stage_ff),
      .header_limit (hdr_limit_ff),
      .l4_limit     (l4_limit_ff),
      .sum_ff       (acc_sum),
      .bytes_ff     (acc_bytes),
      .mode_ff      (acc_mode)
   );

   always_comb begin
      acc_valid_in = acc_free ? stage_go : acc_valid_ff;
      acc_last_in  = stage_go ? stage_ff.last_item : acc_last_ff;

      // add region length in L4 mode, then complement
      final_sum    = acc_mode ? oc_add16(acc_sum, acc_bytes) : acc_sum;
      rsp_valid_in = out_free ? (acc_go && acc_last_ff) : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free && acc_go && acc_last_ff) begin
         rsp_data_in.checksum     = ~final_sum;
         rsp_data_in.region_bytes = acc_bytes;
      end
   end

   always_comb begin
      hdr_limit_in = hdr_limit_ff;
      l4_limit_in  = l4_limit_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HEADER_LIMIT: hdr_limit_in = csr_data;
            CSR_L4_LIMIT:     l4_limit_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         acc_valid_ff   <= 1'b0;
         acc_last_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         hdr_limit_ff   <= HEADER_LIMIT_RESET;
         l4_limit_ff    <= L4_LIMIT_RESET;
      end else begin
         stage_valid_ff <= stage_valid_in;
         acc_valid_ff   <= acc_valid_in;
         acc_last_ff    <= acc_last_in;
         rsp_valid_ff   <= rsp_valid_in;
         hdr_limit_ff   <= hdr_limit_in;
         l4_limit_ff    <= l4_limit_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff    <= stage_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
